// File: src/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg: shared types and constants for the thermistor linearizer
// Field widths, request kinds, register indexes, sequencer states, divider
// request and response types, and the 16-bit saturation helper.
// ----------------------------------------------------------------------------
package tlt_pkg;

   localparam int ADC_W      = 10;
   localparam int TEMP_W     = 16;
   localparam int TICK_W     = 24;
   localparam int DELTA_W    = 15;
   localparam int ENTRIES_W  = 5;
   localparam int INDEX_W    = 4;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   localparam int DEFAULT_TABLE_DEPTH = 16;

   localparam int PROD_W    = 28;
   localparam int DIV_NUM_W = 26;
   localparam int DIV_DEN_W = 10;

   localparam logic [ENTRIES_W-1:0]     ENTRIES_RESET  = 5'd2;
   localparam logic [TICK_W-1:0]        INTERVAL_RESET = 24'd10;
   localparam logic [DELTA_W-1:0]       DELTA_RESET    = 15'd16;
   localparam logic signed [TEMP_W-1:0] CURRENT_RESET  = -16'sd16;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX       = 16'sh7fff;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN       = 16'sh8000;
   localparam logic [TICK_W-1:0]        TICK_SAT       = 24'hffffff;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE    = 2'd0,
      OP_CALIBRATE = 2'd1,
      OP_LOAD      = 2'd2,
      OP_TICK      = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ENTRIES_USED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA        = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CHECK,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_INTERP,
      ST_COMMIT,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [PROD_W-1:0] v);
      logic signed [TEMP_W-1:0] r;
      if (v > 28'sd32767) begin
         r = TEMP_MAX;
      end else if (v < -28'sd32768) begin
         r = TEMP_MIN;
      end else begin
         r = v[TEMP_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: src/thermistor_linearize_track_report.sv
// ----------------------------------------------------------------------------
// thermistor_linearize_track_report: table-driven thermistor linearizer
// Piecewise linear table lookup with min/max tracking and report timing.
//
// Usage:
//  req channel: tuser carries the request kind (sample, calibrate, load
//  breakpoint, tick); tdata carries the operand fields. Each request gives
//  exactly one response on the rsp channel with the calibrated temperature,
//  running minimum and maximum, and the two report flags.
//  csr port: registers are written with csr_we, csr_index and csr_wdata; the
//  user writes them only while no request is in flight (not enforced here).
//  Calibrate, load and tick go from acceptance to the reply state, which
//  loads the response register. A sample reads the table RAM once per
//  fetch and check step until an entry ends the search, then multiplies and
//  starts the divider, which yields one quotient bit per cycle (26 bits).
//  Equal neighbouring thresholds skip the divider.
//  A sample above every breakpoint skips the divider.
//  One request is handled at a time; req_tready is high only when idle.
//  The response sits in an output register, so a new request is taken while
//  it waits; a stalled receiver holds the block before its next response.
//  Reset clears all tracking state; the table holds no data until loaded.
// ----------------------------------------------------------------------------
module thermistor_linearize_track_report #(
   parameter int TABLE_DEPTH = tlt_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // op
   input  logic [tlt_pkg::OP_W-1:0]          req_tuser,
   // adc_value, reference_temp, entry_index, entry_adc, entry_temp
   input  logic [tlt_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // calibrated_temp, lowest_temp, highest_temp, periodic_due, delta_due, zero pad
   output logic [tlt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [tlt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tlt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W = tlt_pkg::ADC_W + tlt_pkg::TEMP_W;

   tlt_pkg::state_type state_ff, state_in;

   logic [tlt_pkg::ADC_W-1:0]          req_adc_value;
   logic signed [tlt_pkg::TEMP_W-1:0]  req_reference_temp;
   logic [tlt_pkg::INDEX_W-1:0]        req_entry_index;
   logic [tlt_pkg::ADC_W-1:0]          req_entry_adc;
   logic signed [tlt_pkg::TEMP_W-1:0]  req_entry_temp;
   logic                               accept;

   logic [tlt_pkg::ENTRIES_W-1:0]      entries_used_ff;
   logic [tlt_pkg::TICK_W-1:0]         interval_ff;
   logic [tlt_pkg::DELTA_W-1:0]        report_delta_ff;

   logic signed [tlt_pkg::TEMP_W-1:0]  current_ff;
   logic signed [tlt_pkg::TEMP_W-1:0]  offset_ff;
   logic signed [tlt_pkg::TEMP_W-1:0]  lowest_ff;
   logic signed [tlt_pkg::TEMP_W-1:0]  highest_ff;
   logic [tlt_pkg::TICK_W-1:0]         tick_ff;
   logic signed [tlt_pkg::TEMP_W-1:0]  last_reported_ff;
   logic                               periodic_ff;
   logic                               delta_due_ff;

   logic [ADDR_W-1:0]                  idx_ff;
   logic [ADDR_W-1:0]                  last_idx;
   logic [tlt_pkg::ADC_W-1:0]          adc_ff;
   logic [tlt_pkg::ADC_W-1:0]          prev_adc_ff;
   logic signed [tlt_pkg::TEMP_W-1:0]  prev_temp_ff;
   logic signed [tlt_pkg::TEMP_W-1:0]  seg_temp_ff;
   logic signed [tlt_pkg::TEMP_W:0]    dt_ff;
   logic signed [tlt_pkg::ADC_W:0]     da_ff;
   logic signed [tlt_pkg::ADC_W:0]     den_ff;
   logic signed [tlt_pkg::PROD_W-1:0]  num_ff;
   logic signed [tlt_pkg::PROD_W-1:0]  q_ff;
   logic                               qneg_ff;
   logic signed [tlt_pkg::TEMP_W-1:0]  temp_ff;

   logic                               ram_we;
   logic                               ram_re;
   logic [ENTRY_W-1:0]                 ram_rd_data;
   logic [tlt_pkg::ADC_W-1:0]          rd_adc;
   logic signed [tlt_pkg::TEMP_W-1:0]  rd_temp;
   logic                               hit;

   tlt_pkg::div_req_type               div_req;
   tlt_pkg::div_rsp_type               div_rsp;
   logic signed [tlt_pkg::PROD_W-1:0]  num_abs;
   logic signed [tlt_pkg::ADC_W:0]     den_abs;

   logic [tlt_pkg::TICK_W-1:0]         tick_inc;
   logic signed [tlt_pkg::TEMP_W:0]    move;
   logic signed [tlt_pkg::TEMP_W:0]    move_abs;

   logic                               rsp_valid_ff;
   logic                               rsp_load;
   logic [tlt_pkg::RSP_DATA_W-1:0]     rsp_data_ff;
   logic signed [tlt_pkg::TEMP_W-1:0]  calibrated;

   assign req_adc_value      = req_tdata[9:0];
   assign req_reference_temp = req_tdata[25:10];
   assign req_entry_index    = req_tdata[29:26];
   assign req_entry_adc      = req_tdata[39:30];
   assign req_entry_temp     = req_tdata[55:40];

   assign accept  = req_tvalid && req_tready;
   assign rd_adc  = ram_rd_data[tlt_pkg::ADC_W-1:0];
   assign rd_temp = ram_rd_data[ENTRY_W-1:tlt_pkg::ADC_W];
   assign hit     = adc_ff < rd_adc;

   always_comb begin
      priority if (32'(entries_used_ff) < 2) begin
         last_idx = ADDR_W'(1);
      end else if (32'(entries_used_ff) > TABLE_DEPTH) begin
         last_idx = ADDR_W'(TABLE_DEPTH - 1);
      end else begin
         last_idx = ADDR_W'(entries_used_ff - 5'd1);
      end
   end

   tlt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data ({req_entry_temp, req_entry_adc}),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign num_abs = num_ff[tlt_pkg::PROD_W-1] ? -num_ff : num_ff;
   assign den_abs = den_ff[tlt_pkg::ADC_W] ? -den_ff : den_ff;

   tlt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (tlt_pkg::op_type'(req_tuser) == tlt_pkg::OP_SAMPLE) ?
                          tlt_pkg::ST_FETCH : tlt_pkg::ST_REPLY;
            end
         end
         tlt_pkg::ST_FETCH: state_in = tlt_pkg::ST_CHECK;
         tlt_pkg::ST_CHECK: begin
            priority if (idx_ff == '0) begin
               state_in = tlt_pkg::ST_FETCH;
            end else if (hit) begin
               state_in = tlt_pkg::ST_MUL;
            end else if (idx_ff == last_idx) begin
               state_in = tlt_pkg::ST_COMMIT;
            end else begin
               state_in = tlt_pkg::ST_FETCH;
            end
         end
         tlt_pkg::ST_MUL: state_in = tlt_pkg::ST_DIV_GO;
         tlt_pkg::ST_DIV_GO: begin
            state_in = (den_ff == '0) ? tlt_pkg::ST_INTERP : tlt_pkg::ST_DIV_WAIT;
         end
         tlt_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = tlt_pkg::ST_INTERP;
            end
         end
         tlt_pkg::ST_INTERP: state_in = tlt_pkg::ST_COMMIT;
         tlt_pkg::ST_COMMIT: state_in = tlt_pkg::ST_REPLY;
         tlt_pkg::ST_REPLY: begin
            if (rsp_load) begin
               state_in = tlt_pkg::ST_IDLE;
            end
         end
         default: state_in = tlt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready       = (state_ff == tlt_pkg::ST_IDLE);
      ram_we           = accept && (tlt_pkg::op_type'(req_tuser) == tlt_pkg::OP_LOAD) &&
                         (32'(req_entry_index) < TABLE_DEPTH);
      ram_re           = (state_ff == tlt_pkg::ST_FETCH);
      div_req.start    = (state_ff == tlt_pkg::ST_DIV_GO) && (den_ff != '0);
      div_req.dividend = num_abs[tlt_pkg::DIV_NUM_W-1:0];
      div_req.divisor  = den_abs[tlt_pkg::DIV_DEN_W-1:0];
      rsp_load         = (state_ff == tlt_pkg::ST_REPLY) && (!rsp_valid_ff || rsp_tready);
   end

   assign tick_inc = (tick_ff != tlt_pkg::TICK_SAT) ? tick_ff + 1'b1 : tick_ff;
   assign move     = (tlt_pkg::TEMP_W+1)'(last_reported_ff) - (tlt_pkg::TEMP_W+1)'(current_ff);
   assign move_abs = move[tlt_pkg::TEMP_W] ? -move : move;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tlt_pkg::ST_IDLE;
         entries_used_ff <= tlt_pkg::ENTRIES_RESET;
         interval_ff     <= tlt_pkg::INTERVAL_RESET;
         report_delta_ff <= tlt_pkg::DELTA_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               tlt_pkg::CSR_ENTRIES_USED:
                  entries_used_ff <= csr_wdata[tlt_pkg::ENTRIES_W-1:0];
               tlt_pkg::CSR_INTERVAL: interval_ff <= csr_wdata[tlt_pkg::TICK_W-1:0];
               tlt_pkg::CSR_DELTA: report_delta_ff <= csr_wdata[tlt_pkg::DELTA_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff       <= tlt_pkg::CURRENT_RESET;
         offset_ff        <= '0;
         lowest_ff        <= tlt_pkg::TEMP_MAX;
         highest_ff       <= tlt_pkg::TEMP_MIN;
         tick_ff          <= '0;
         last_reported_ff <= '0;
         periodic_ff      <= 1'b0;
         delta_due_ff     <= 1'b0;
      end else begin
         if (accept) begin
            periodic_ff  <= 1'b0;
            delta_due_ff <= 1'b0;
            unique case (tlt_pkg::op_type'(req_tuser))
               tlt_pkg::OP_SAMPLE: ;
               tlt_pkg::OP_CALIBRATE: begin
                  offset_ff <= tlt_pkg::sat_temp(tlt_pkg::PROD_W'(req_reference_temp) -
                                                 tlt_pkg::PROD_W'(current_ff));
               end
               tlt_pkg::OP_LOAD: ;
               tlt_pkg::OP_TICK: begin
                  if (tick_inc >= interval_ff) begin
                     tick_ff     <= '0;
                     periodic_ff <= 1'b1;
                  end else begin
                     tick_ff <= tick_inc;
                  end
                  if ($unsigned(move_abs) > (tlt_pkg::TEMP_W+1)'(report_delta_ff)) begin
                     last_reported_ff <= current_ff;
                     delta_due_ff     <= 1'b1;
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == tlt_pkg::ST_COMMIT) begin
            current_ff <= temp_ff;
            if (temp_ff > highest_ff) begin
               highest_ff <= temp_ff;
            end
            if (temp_ff < lowest_ff) begin
               lowest_ff <= temp_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         adc_ff <= req_adc_value;
         idx_ff <= '0;
      end
      unique case (state_ff)
         tlt_pkg::ST_CHECK: begin
            priority if (idx_ff == '0) begin
               prev_adc_ff  <= rd_adc;
               prev_temp_ff <= rd_temp;
               idx_ff       <= idx_ff + 1'b1;
            end else if (hit) begin
               seg_temp_ff <= rd_temp;
               dt_ff  <= (tlt_pkg::TEMP_W+1)'(rd_temp) - (tlt_pkg::TEMP_W+1)'(prev_temp_ff);
               da_ff  <= $signed({1'b0, adc_ff}) - $signed({1'b0, rd_adc});
               den_ff <= $signed({1'b0, prev_adc_ff}) - $signed({1'b0, rd_adc});
            end else if (idx_ff == last_idx) begin
               temp_ff <= rd_temp;
            end else begin
               prev_adc_ff  <= rd_adc;
               prev_temp_ff <= rd_temp;
               idx_ff       <= idx_ff + 1'b1;
            end
         end
         tlt_pkg::ST_MUL: num_ff <= tlt_pkg::PROD_W'(dt_ff) * tlt_pkg::PROD_W'(da_ff);
         tlt_pkg::ST_DIV_GO: begin
            qneg_ff <= num_ff[tlt_pkg::PROD_W-1] ^ den_ff[tlt_pkg::ADC_W];
            q_ff    <= '0;
         end
         tlt_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               q_ff <= qneg_ff ? -$signed({2'b00, div_rsp.quotient}) :
                                 $signed({2'b00, div_rsp.quotient});
            end
         end
         tlt_pkg::ST_INTERP: begin
            temp_ff <= tlt_pkg::sat_temp(tlt_pkg::PROD_W'(seg_temp_ff) - q_ff);
         end
         default: ;
      endcase
   end

   assign calibrated = tlt_pkg::sat_temp(tlt_pkg::PROD_W'(current_ff) +
                                         tlt_pkg::PROD_W'(offset_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {6'd0, delta_due_ff, periodic_ff, highest_ff, lowest_ff, calibrated};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_minmax_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlt_pkg::ST_COMMIT) |=> (lowest_ff <= highest_ff))
      else $error("running minimum above running maximum after a sample");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlt_pkg::ST_FETCH) |-> (idx_ff <= last_idx))
      else $error("table search beyond the used entries");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (div_req.divisor != '0))
      else $error("divider started with a zero divisor");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == tlt_pkg::ST_DIV_WAIT))
      else $error("divider finished outside the wait state");

endmodule

// File: src/tlt_ram.sv
// ----------------------------------------------------------------------------
// tlt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tlt_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/tlt_div.sv
// ----------------------------------------------------------------------------
// tlt_div: unsigned restoring divider, one quotient bit per cycle
// Takes a start pulse with magnitudes, pulses done with the quotient.
// ----------------------------------------------------------------------------
module tlt_div (
   input  logic                clock,
   input  logic                reset,
   input  tlt_pkg::div_req_type div_req,
   output tlt_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(tlt_pkg::DIV_NUM_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(tlt_pkg::DIV_NUM_W - 1);

   logic [tlt_pkg::DIV_DEN_W-1:0] rem_ff;
   logic [tlt_pkg::DIV_DEN_W-1:0] rem_in;
   logic [tlt_pkg::DIV_NUM_W-1:0] quo_ff;
   logic [tlt_pkg::DIV_DEN_W-1:0] dsr_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;
   logic [tlt_pkg::DIV_DEN_W:0]   trial;
   logic [tlt_pkg::DIV_DEN_W:0]   diff;
   logic                          fits;

   assign trial = {rem_ff, quo_ff[tlt_pkg::DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};
   assign rem_in = fits ? diff[tlt_pkg::DIV_DEN_W-1:0] : trial[tlt_pkg::DIV_DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         quo_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[tlt_pkg::DIV_NUM_W-2:0], fits};
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule
